@@ hw/rtl/wsts_pkg.sv @@
// Shared types and constants of the weighted server task scheduler.
package wsts_pkg;

  localparam int unsigned OPCODE_W   = 1;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned WEIGHT_W   = 20;
  localparam int unsigned DUR_W      = 20;
  localparam int unsigned OUT_SRV_W  = 4;
  localparam int unsigned OUT_TIME_W = 40;
  localparam int unsigned ACTIVE_W   = 5;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  localparam logic [OPCODE_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_TASK = 1'b1;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [SLOT_W-1:0]   server_slot;
    logic [WEIGHT_W-1:0] server_weight;
    logic [DUR_W-1:0]    task_duration;
  } in_item_t;

  typedef struct packed {
    logic [OUT_SRV_W-1:0]  assigned_server;
    logic [OUT_TIME_W-1:0] start_time;
  } out_item_t;

endpackage

@@ hw/rtl/weighted_server_task_scheduler_core.sv @@
// Top level of the weighted server task scheduler: sequencer, tables and result register.
//
// A load beat (opcode load) writes one server weight in the cycle it is taken and yields
// no result. A task beat is timed by two passes of one compare datapath over the active
// servers, each pass reading one server per cycle from the free-time and weight tables
// (registered reads): the first pass finds the earliest free time and whether any server
// is free at the candidate start, the second picks the lightest free server, lowest index
// on ties. The input is stalled in every state but idle, so a task holds the block through
// both passes and the finish state before the next beat is accepted. The result sits in an
// output register, so a new beat is taken while a finished result still waits downstream;
// a task completes only once that register is free. Reset clears the tables through per-entry
// valid bits, with no clearing pass. active_servers is written through cfg_wr_en / cfg_wr_data;
// zero acts as one and values above NUM_SERVERS act as NUM_SERVERS. Times saturate at the
// TIME_BITS maximum; start_time shows the low bits of the internal start time.
module weighted_server_task_scheduler_core #(
  parameter int unsigned NUM_SERVERS = 16,
  parameter int unsigned TIME_BITS   = 40
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  wsts_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output wsts_pkg::out_item_t                  out_data,
  input  logic                                 cfg_wr_en,
  input  logic [wsts_pkg::ACTIVE_W-1:0]        cfg_wr_data
);

  // index and count widths
  localparam int unsigned SW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int unsigned CW = $clog2(NUM_SERVERS + 1);
  localparam int unsigned XW = 9; // holds any count up to 256 and any slot
  localparam int unsigned AW = ((TIME_BITS > wsts_pkg::DUR_W) ? TIME_BITS
                                                              : wsts_pkg::DUR_W) + 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN1 = 4'b0010,
    ST_SCAN2 = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [wsts_pkg::ACTIVE_W-1:0] active_r;

  // time state
  logic [TIME_BITS-1:0] last_start_r, task_num_r, start_r, earliest_r;
  logic                 any_free_r;

  // task context
  logic [CW-1:0]             n_r;
  logic [wsts_pkg::DUR_W-1:0] dur_r;

  // scan pipeline: issue counter, then a registered table read
  logic [CW-1:0] iss_r;
  logic          dv_r, dfirst_r, dlast_r;
  logic [SW-1:0] didx_r;

  // second pass winner
  logic                       best_ok_r;
  logic [SW-1:0]              best_r;
  logic [wsts_pkg::WEIGHT_W-1:0] best_w_r;

  // tables
  logic [TIME_BITS-1:0]          fa_mem [NUM_SERVERS];
  logic [wsts_pkg::WEIGHT_W-1:0] wt_mem [NUM_SERVERS];
  logic [NUM_SERVERS-1:0]        fa_vld_r, wt_vld_r;
  logic [TIME_BITS-1:0]          fa_q_r;
  logic [wsts_pkg::WEIGHT_W-1:0] wt_q_r;
  logic                          fa_vq_r, wt_vq_r;

  logic                 out_valid_r;
  wsts_pkg::out_item_t  out_data_r;

  // handshakes
  logic in_fire, load_fire, task_fire, fin_fire, issuing, scan_done;
  logic [XW-1:0] slot_x, act_x, n_x;
  logic [CW-1:0] n_sel;
  logic [SW-1:0] rd_addr;

  // scan datapath
  logic [TIME_BITS-1:0]          fa_rd;
  logic [wsts_pkg::WEIGHT_W-1:0] wt_rd;
  logic                          fa_le_start;
  logic                          any_free_nxt;
  logic [TIME_BITS-1:0]          earliest_nxt;
  logic                          take;
  logic [SW-1:0]                 best_nxt;
  logic [AW-1:0]                 fin_sum;
  logic [TIME_BITS-1:0]          fin_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign load_fire = in_fire && (in_data.opcode == wsts_pkg::OP_LOAD);
  assign task_fire = in_fire && (in_data.opcode == wsts_pkg::OP_TASK);
  assign fin_fire  = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  // clamp the active count into 1..NUM_SERVERS
  assign act_x = XW'(active_r);
  always_comb begin
    priority if (act_x == '0) begin
      n_x = XW'(1);
    end else if (act_x > XW'(NUM_SERVERS)) begin
      n_x = XW'(NUM_SERVERS);
    end else begin
      n_x = act_x;
    end
  end
  assign n_sel = n_x[CW-1:0];

  assign slot_x = XW'(in_data.server_slot);

  // scan issue: one table address per cycle until n reads are out
  assign issuing   = ((state_r == ST_SCAN1) || (state_r == ST_SCAN2)) && (iss_r != n_r);
  assign rd_addr   = iss_r[SW-1:0];
  assign scan_done = dv_r && dlast_r;

  // never-written entries read as zero
  assign fa_rd = fa_vq_r ? fa_q_r : '0;
  assign wt_rd = wt_vq_r ? wt_q_r : '0;

  // shared compare unit
  assign fa_le_start  = (fa_rd <= start_r);
  assign any_free_nxt = (dfirst_r ? 1'b0 : any_free_r) | fa_le_start;
  assign earliest_nxt = (dfirst_r || (fa_rd < earliest_r)) ? fa_rd : earliest_r;
  assign take         = fa_le_start && (!best_ok_r || (wt_rd < best_w_r));
  assign best_nxt     = take ? didx_r : best_r;

  // saturating free time of the chosen server
  assign fin_sum  = AW'(start_r) + AW'(dur_r);
  assign fin_free = (|fin_sum[AW-1:TIME_BITS]) ? {TIME_BITS{1'b1}}
                                               : fin_sum[TIME_BITS-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (task_fire) state_nxt = ST_SCAN1;
      ST_SCAN1: if (scan_done) state_nxt = ST_SCAN2;
      ST_SCAN2: if (scan_done) state_nxt = ST_FIN;
      ST_FIN:   if (fin_fire)  state_nxt = ST_IDLE;
      default:                 state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      active_r     <= wsts_pkg::ACTIVE_RESET;
      last_start_r <= '0;
      task_num_r   <= '0;
      fa_vld_r     <= '0;
      wt_vld_r     <= '0;
      out_valid_r  <= 1'b0;
      dv_r         <= 1'b0;
      iss_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) active_r <= cfg_wr_data;

      if (load_fire && (slot_x < XW'(NUM_SERVERS))) wt_vld_r[slot_x[SW-1:0]] <= 1'b1;

      dv_r <= issuing;
      if (issuing) begin
        iss_r <= CW'(iss_r + CW'(1));
      end else if (scan_done) begin
        iss_r <= '0; // rearm for the second pass
      end else if (task_fire) begin
        iss_r <= '0;
      end

      if (fin_fire) begin
        fa_vld_r[best_r] <= 1'b1;
        last_start_r     <= start_r;
        task_num_r       <= (&task_num_r) ? task_num_r
                                          : TIME_BITS'(task_num_r + TIME_BITS'(1));
      end

      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    dfirst_r <= (iss_r == '0);
    dlast_r  <= (CW'(iss_r + CW'(1)) == n_r);
    didx_r   <= rd_addr;

    if (task_fire) begin
      n_r     <= n_sel;
      dur_r   <= in_data.task_duration;
      start_r <= (last_start_r > task_num_r) ? last_start_r : task_num_r;
    end

    if ((state_r == ST_SCAN1) && dv_r) begin
      any_free_r <= any_free_nxt;
      earliest_r <= earliest_nxt;
      if (dlast_r && !any_free_nxt) start_r <= earliest_nxt;
    end

    if (state_r == ST_SCAN1) begin
      best_ok_r <= 1'b0;
      best_r    <= '0;
    end else if ((state_r == ST_SCAN2) && dv_r && take) begin
      best_ok_r <= 1'b1;
      best_r    <= best_nxt;
      best_w_r  <= wt_rd;
    end

    if (fin_fire) begin
      out_data_r.assigned_server <= wsts_pkg::OUT_SRV_W'(best_r);
      out_data_r.start_time      <= wsts_pkg::OUT_TIME_W'(start_r);
    end
  end

  // free-time table
  always_ff @(posedge clk) begin
    if (fin_fire) fa_mem[best_r] <= fin_free;
    fa_q_r <= fa_mem[rd_addr];
  end

  // weight table
  always_ff @(posedge clk) begin
    if (load_fire && (slot_x < XW'(NUM_SERVERS))) begin
      wt_mem[slot_x[SW-1:0]] <= in_data.server_weight;
    end
    wt_q_r <= wt_mem[rd_addr];
  end

  // valid bits sampled with the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_vq_r <= 1'b0;
      wt_vq_r <= 1'b0;
    end else begin
      fa_vq_r <= fa_vld_r[rd_addr];
      wt_vq_r <= wt_vld_r[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
